@@ rtl/core/pkc_pkg.sv @@
// Package for the priority keyword classifier: keyword table, codes, result type.
`default_nettype none
package pkc_pkg;

	// Window holds the current byte plus WINDOW_LEN-1 earlier bytes
	localparam int WINDOW_LEN    = 17;
	localparam int TABLE_SIZE    = 46;
	localparam int PATTERN_COUNT = 46;
	localparam int ACTIVE_COUNT  = (PATTERN_COUNT < TABLE_SIZE) ? PATTERN_COUNT : TABLE_SIZE;
	// Longest keyword in bytes
	localparam int KW_BYTES      = 17;
	localparam int WIN_EXT       = (WINDOW_LEN > KW_BYTES) ? WINDOW_LEN : KW_BYTES;
	localparam int IDX_W         = 6;

	// Threat levels
	localparam logic [2:0] LVL_NONE     = 3'd0;
	localparam logic [2:0] LVL_LOW      = 3'd1;
	localparam logic [2:0] LVL_MEDIUM   = 3'd2;
	localparam logic [2:0] LVL_HIGH     = 3'd3;
	localparam logic [2:0] LVL_CRITICAL = 3'd4;

	// Categories
	localparam logic [2:0] CAT_GENERAL    = 3'd0;
	localparam logic [2:0] CAT_CONFLICT   = 3'd1;
	localparam logic [2:0] CAT_MARKET     = 3'd2;
	localparam logic [2:0] CAT_CYBER      = 3'd3;
	localparam logic [2:0] CAT_REGULATORY = 3'd4;
	localparam logic [2:0] CAT_NATURAL    = 3'd5;

	// Fallback confidence when nothing matched
	localparam logic [6:0] CONF_BEARISH = 7'd40;
	localparam logic [6:0] CONF_DEFAULT = 7'd30;

	// Keyword text is right aligned: byte 0 is the last character, unused bytes are zero
	typedef struct packed {
		logic [KW_BYTES-1:0][7:0] text;
		logic [2:0]               level;
		logic [2:0]               cat;
		logic [6:0]               conf;
	} kw_t;

	typedef struct packed {
		logic [2:0]       level;
		logic [2:0]       cat;
		logic [6:0]       conf;
		logic [IDX_W-1:0] index;
	} res_t;

	localparam kw_t KW_TABLE [TABLE_SIZE] = '{
		'{"nuclear strike",    LVL_CRITICAL, CAT_CONFLICT,   7'd95},
		'{"nuclear attack",    LVL_CRITICAL, CAT_CONFLICT,   7'd95},
		'{"war declared",      LVL_CRITICAL, CAT_CONFLICT,   7'd95},
		'{"market crash",      LVL_CRITICAL, CAT_MARKET,     7'd90},
		'{"flash crash",       LVL_CRITICAL, CAT_MARKET,     7'd90},
		'{"circuit breaker",   LVL_CRITICAL, CAT_MARKET,     7'd85},
		'{"trading halt",      LVL_CRITICAL, CAT_MARKET,     7'd85},
		'{"bank run",          LVL_CRITICAL, CAT_MARKET,     7'd90},
		'{"sovereign default", LVL_CRITICAL, CAT_MARKET,     7'd90},
		'{"cyberattack",       LVL_HIGH,     CAT_CYBER,      7'd80},
		'{"data breach",       LVL_HIGH,     CAT_CYBER,      7'd75},
		'{"ransomware",        LVL_HIGH,     CAT_CYBER,      7'd80},
		'{"invasion",          LVL_HIGH,     CAT_CONFLICT,   7'd85},
		'{"airstrike",         LVL_HIGH,     CAT_CONFLICT,   7'd85},
		'{"missile launch",    LVL_HIGH,     CAT_CONFLICT,   7'd85},
		'{"military deploy",   LVL_HIGH,     CAT_CONFLICT,   7'd80},
		'{"coup attempt",      LVL_HIGH,     CAT_CONFLICT,   7'd85},
		'{"martial law",       LVL_HIGH,     CAT_CONFLICT,   7'd85},
		'{"bankruptcy fil",    LVL_HIGH,     CAT_MARKET,     7'd80},
		'{"rate hike",         LVL_HIGH,     CAT_MARKET,     7'd70},
		'{"rate cut",          LVL_HIGH,     CAT_MARKET,     7'd70},
		'{"earnings miss",     LVL_HIGH,     CAT_MARKET,     7'd75},
		'{"profit warning",    LVL_HIGH,     CAT_MARKET,     7'd75},
		'{"downgrad",          LVL_HIGH,     CAT_MARKET,     7'd70},
		'{"sanction",          LVL_HIGH,     CAT_REGULATORY, 7'd70},
		'{"embargo",           LVL_HIGH,     CAT_REGULATORY, 7'd75},
		'{"earthquake",        LVL_HIGH,     CAT_NATURAL,    7'd80},
		'{"tsunami",           LVL_HIGH,     CAT_NATURAL,    7'd85},
		'{"hurricane",         LVL_HIGH,     CAT_NATURAL,    7'd75},
		'{"pandemic",          LVL_HIGH,     CAT_NATURAL,    7'd80},
		'{"protest",           LVL_MEDIUM,   CAT_CONFLICT,   7'd60},
		'{"riot",              LVL_MEDIUM,   CAT_CONFLICT,   7'd70},
		'{"tension",           LVL_MEDIUM,   CAT_CONFLICT,   7'd50},
		'{"escalat",           LVL_MEDIUM,   CAT_CONFLICT,   7'd65},
		'{"tariff",            LVL_MEDIUM,   CAT_REGULATORY, 7'd65},
		'{"regulation",        LVL_MEDIUM,   CAT_REGULATORY, 7'd50},
		'{"antitrust",         LVL_MEDIUM,   CAT_REGULATORY, 7'd60},
		'{"investigat",        LVL_MEDIUM,   CAT_REGULATORY, 7'd55},
		'{"layoff",            LVL_MEDIUM,   CAT_MARKET,     7'd60},
		'{"recession",         LVL_MEDIUM,   CAT_MARKET,     7'd65},
		'{"inflation",         LVL_MEDIUM,   CAT_MARKET,     7'd55},
		'{"selloff",           LVL_MEDIUM,   CAT_MARKET,     7'd60},
		'{"sell-off",          LVL_MEDIUM,   CAT_MARKET,     7'd60},
		'{"volatil",           LVL_MEDIUM,   CAT_MARKET,     7'd50},
		'{"wildfire",          LVL_MEDIUM,   CAT_NATURAL,    7'd60},
		'{"flood",             LVL_MEDIUM,   CAT_NATURAL,    7'd60}
	};

	// Fold ASCII upper case letters to lower case
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b inside {[8'h41:8'h5A]}) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/pkc_match.sv @@
// Byte window and parallel keyword comparators.
`default_nettype none
module pkc_match (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [7:0]                       raw_byte,
	input  wire logic                             shift,
	input  wire logic                             last,
	output logic      [pkc_pkg::ACTIVE_COUNT-1:0] hits
);
	import pkc_pkg::*;

	logic [WINDOW_LEN-2:0][7:0] window_q;
	logic [WIN_EXT-1:0][7:0]    win;

	// Current folded byte at position 0, older bytes above, zero past the window
	always_comb begin
		win = '0;
		win[0] = fold_case(raw_byte);
		for (int i = 1; i < WINDOW_LEN; i++) begin
			win[i] = window_q[i-1];
		end
	end

	// One comparator per keyword; zero keyword bytes are padding and always agree
	always_comb begin
		hits = '1;
		for (int p = 0; p < ACTIVE_COUNT; p++) begin
			for (int i = 0; i < KW_BYTES; i++) begin
				if (KW_TABLE[p].text[i] != 8'h00) begin
					if (i >= WINDOW_LEN || KW_TABLE[p].text[i] != win[i]) begin
						hits[p] = 1'b0;
					end
				end
			end
		end
	end

	// Window shifts on each item and clears after the last byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (shift) begin
			if (last) begin
				window_q <= '0;
			end else begin
				window_q <= win[WINDOW_LEN-2:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && last) |=> (window_q == '0))
		else $error("window not cleared after end of text");
	a_window_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!shift |=> $stable(window_q))
		else $error("window changed without an item");
	a_window_newest: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && !last) |=> (window_q[0] == $past(fold_case(raw_byte))))
		else $error("newest window byte wrong");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pkc_resolve.sv @@
// Sticky match bitmap and lowest-index priority selection.
`default_nettype none
module pkc_resolve (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [pkc_pkg::ACTIVE_COUNT-1:0] hits,
	input  wire logic                             adv,
	input  wire logic                             last,
	input  wire logic                             bearish,
	output pkc_pkg::res_t                         res
);
	import pkc_pkg::*;

	logic [ACTIVE_COUNT-1:0] bitmap_q;
	logic [ACTIVE_COUNT-1:0] vec;

	assign vec = bitmap_q | hits;

	// Fallback first, then scan from the top so the lowest set index wins
	always_comb begin
		res.level = bearish ? LVL_LOW : LVL_NONE;
		res.cat   = CAT_GENERAL;
		res.conf  = bearish ? CONF_BEARISH : CONF_DEFAULT;
		res.index = IDX_W'(ACTIVE_COUNT);
		for (int i = ACTIVE_COUNT - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res.level = KW_TABLE[i].level;
				res.cat   = KW_TABLE[i].cat;
				res.conf  = KW_TABLE[i].conf;
				res.index = IDX_W'(i);
			end
		end
	end

	// Bitmap collects hits across a text and clears at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q <= '0;
		end else if (adv) begin
			if (last) begin
				bitmap_q <= '0;
			end else begin
				bitmap_q <= vec;
			end
		end
	end

`ifndef SYNTHESIS
	a_bitmap_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last) |=> (bitmap_q == '0))
		else $error("bitmap not cleared after end of text");
	a_bitmap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last) |=> ((bitmap_q & $past(vec)) == $past(vec)))
		else $error("bitmap lost a match");
	a_bitmap_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(bitmap_q))
		else $error("bitmap changed without an item");
`endif

endmodule
`default_nettype wire

@@ rtl/core/priority_keyword_classifier.sv @@
// Top level: input register, match stage, priority select and result register.
// Throughput: one byte per cycle while no final byte waits in the match register.
// Bytes that end no text keep flowing while a result waits in the result register.
// Each accepted byte passes the input register, the keyword comparators, then the bitmap/select.
// Reset (arst_n low, asynchronous) empties the pipeline, zeroes the window and the bitmap.
// An end-of-text item stalls only while the result register is still full.
`default_nettype none
module priority_keyword_classifier (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	input  wire logic       bearish,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      threat_level,
	output logic [2:0]      category,
	output logic [6:0]      confidence_pct,
	output logic [5:0]      pattern_index
);
	import pkc_pkg::*;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	logic                    bear_s1;
	logic                    valid_s2;
	logic [ACTIVE_COUNT-1:0] hits_s2;
	logic                    last_s2;
	logic                    bear_s2;
	logic                    out_valid_q;
	res_t                    out_q;

	logic                    out_free;
	logic                    adv_s2;
	logic                    adv_s1;
	logic                    in_take;
	logic [ACTIVE_COUNT-1:0] hits;
	res_t                    res;

	// Pipeline flow: only a final byte needs room in the result register
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s2   = valid_s2 && (!last_s2 || out_free);
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_s2);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	pkc_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw_byte (byte_s1),
		.shift    (adv_s1),
		.last     (last_s1),
		.hits     (hits)
	);

	pkc_resolve u_resolve (
		.clk     (clk),
		.arst_n  (arst_n),
		.hits    (hits_s2),
		.adv     (adv_s2),
		.last    (last_s2),
		.bearish (bear_s2),
		.res     (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
			bear_s1 <= bearish;
		end
	end

	// Match register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hits_s2 <= hits;
			last_s2 <= last_s1;
			bear_s2 <= bear_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && last_s2) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign threat_level   = out_q.level;
	assign category       = out_q.cat;
	assign confidence_pct = out_q.conf;
	assign pattern_index  = out_q.index;

`ifndef SYNTHESIS
	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2 && out_valid_q && out_stall) |=> (valid_s2 && last_s2))
		else $error("final item dropped while result register full");
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && last_s2))
		else $error("input stalled with no blocking final item");
	a_fallback_conf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pattern_index == IDX_W'(ACTIVE_COUNT)) |->
		(confidence_pct == CONF_BEARISH || confidence_pct == CONF_DEFAULT))
		else $error("fallback result has wrong confidence");
	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv_s2 && last_s2))
		else $error("result appeared without a final item");
`endif

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the priority keyword classifier: text stream driver, verdict predictor, checker.
`default_nettype none
module tb_top;
	import pkc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1150;
	localparam int MIN_TEXTS   = 48;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 600;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       bear;
	} text_item_t;

	typedef struct packed {
		logic [2:0] level;
		logic [2:0] cat;
		logic [6:0] conf;
		logic [5:0] index;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       bearish = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] threat_level;
	logic [2:0] category;
	logic [6:0] confidence_pct;
	logic [5:0] pattern_index;

	priority_keyword_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.bearish(bearish),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.threat_level(threat_level),
		.category(category),
		.confidence_pct(confidence_pct),
		.pattern_index(pattern_index)
	);

	always #10 clk = ~clk;

	// Keyword list in priority order, with {level, category, confidence}
	string kw_text [TABLE_SIZE] = '{
		"nuclear strike", "nuclear attack", "war declared", "market crash",
		"flash crash", "circuit breaker", "trading halt", "bank run",
		"sovereign default", "cyberattack", "data breach", "ransomware",
		"invasion", "airstrike", "missile launch", "military deploy",
		"coup attempt", "martial law", "bankruptcy fil", "rate hike",
		"rate cut", "earnings miss", "profit warning", "downgrad",
		"sanction", "embargo", "earthquake", "tsunami",
		"hurricane", "pandemic", "protest", "riot",
		"tension", "escalat", "tariff", "regulation",
		"antitrust", "investigat", "layoff", "recession",
		"inflation", "selloff", "sell-off", "volatil",
		"wildfire", "flood"
	};

	logic [12:0] kw_grade [TABLE_SIZE] = '{
		{LVL_CRITICAL, CAT_CONFLICT, 7'd95}, {LVL_CRITICAL, CAT_CONFLICT, 7'd95},
		{LVL_CRITICAL, CAT_CONFLICT, 7'd95}, {LVL_CRITICAL, CAT_MARKET, 7'd90},
		{LVL_CRITICAL, CAT_MARKET, 7'd90},   {LVL_CRITICAL, CAT_MARKET, 7'd85},
		{LVL_CRITICAL, CAT_MARKET, 7'd85},   {LVL_CRITICAL, CAT_MARKET, 7'd90},
		{LVL_CRITICAL, CAT_MARKET, 7'd90},
		{LVL_HIGH, CAT_CYBER, 7'd80},        {LVL_HIGH, CAT_CYBER, 7'd75},
		{LVL_HIGH, CAT_CYBER, 7'd80},
		{LVL_HIGH, CAT_CONFLICT, 7'd85},     {LVL_HIGH, CAT_CONFLICT, 7'd85},
		{LVL_HIGH, CAT_CONFLICT, 7'd85},     {LVL_HIGH, CAT_CONFLICT, 7'd80},
		{LVL_HIGH, CAT_CONFLICT, 7'd85},     {LVL_HIGH, CAT_CONFLICT, 7'd85},
		{LVL_HIGH, CAT_MARKET, 7'd80},       {LVL_HIGH, CAT_MARKET, 7'd70},
		{LVL_HIGH, CAT_MARKET, 7'd70},       {LVL_HIGH, CAT_MARKET, 7'd75},
		{LVL_HIGH, CAT_MARKET, 7'd75},       {LVL_HIGH, CAT_MARKET, 7'd70},
		{LVL_HIGH, CAT_REGULATORY, 7'd70},   {LVL_HIGH, CAT_REGULATORY, 7'd75},
		{LVL_HIGH, CAT_NATURAL, 7'd80},      {LVL_HIGH, CAT_NATURAL, 7'd85},
		{LVL_HIGH, CAT_NATURAL, 7'd75},      {LVL_HIGH, CAT_NATURAL, 7'd80},
		{LVL_MEDIUM, CAT_CONFLICT, 7'd60},   {LVL_MEDIUM, CAT_CONFLICT, 7'd70},
		{LVL_MEDIUM, CAT_CONFLICT, 7'd50},   {LVL_MEDIUM, CAT_CONFLICT, 7'd65},
		{LVL_MEDIUM, CAT_REGULATORY, 7'd65}, {LVL_MEDIUM, CAT_REGULATORY, 7'd50},
		{LVL_MEDIUM, CAT_REGULATORY, 7'd60}, {LVL_MEDIUM, CAT_REGULATORY, 7'd55},
		{LVL_MEDIUM, CAT_MARKET, 7'd60},     {LVL_MEDIUM, CAT_MARKET, 7'd65},
		{LVL_MEDIUM, CAT_MARKET, 7'd55},     {LVL_MEDIUM, CAT_MARKET, 7'd60},
		{LVL_MEDIUM, CAT_MARKET, 7'd60},     {LVL_MEDIUM, CAT_MARKET, 7'd50},
		{LVL_MEDIUM, CAT_NATURAL, 7'd60},    {LVL_MEDIUM, CAT_NATURAL, 7'd60}
	};

	text_item_t text_stream_q [$];
	verdict_t   verdict_q [$];

	// Predictor state: recent_bytes[0] is the newest folded byte
	logic [7:0]              recent_bytes [WINDOW_LEN];
	logic [TABLE_SIZE-1:0]   kw_seen = '0;

	int total_items = 0;
	int texts_built = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int level_tally [8];
	int tx_wait = 0;
	int rx_wait = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	initial begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			recent_bytes[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++) begin
			level_tally[i] = 0;
		end
	end

	// Fold, shift into the window, mark keywords ending here; emit a verdict on the last byte
	task automatic classify_byte(input text_item_t it);
		logic [7:0] b;
		logic [7:0] c;
		verdict_t   v;
		string      w;
		int         len;
		bit         hit;
		b = it.ch;
		if (b >= 8'h41 && b <= 8'h5A) begin
			b = b + 8'd32;
		end
		for (int i = WINDOW_LEN - 1; i > 0; i--) begin
			recent_bytes[i] = recent_bytes[i-1];
		end
		recent_bytes[0] = b;
		for (int k = 0; k < ACTIVE_COUNT; k++) begin
			w = kw_text[k];
			len = w.len();
			if (len <= WINDOW_LEN) begin
				hit = 1'b1;
				for (int i = 0; i < len; i++) begin
					c = w[len-1-i];
					if (c != recent_bytes[i]) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					kw_seen[k] = 1'b1;
				end
			end
		end
		if (it.last) begin
			v.level = it.bear ? LVL_LOW : LVL_NONE;
			v.cat   = CAT_GENERAL;
			v.conf  = it.bear ? CONF_BEARISH : CONF_DEFAULT;
			v.index = 6'(ACTIVE_COUNT);
			// walk down so the lowest matched index wins
			for (int k = ACTIVE_COUNT - 1; k >= 0; k--) begin
				if (kw_seen[k]) begin
					{v.level, v.cat, v.conf} = kw_grade[k];
					v.index = 6'(k);
				end
			end
			verdict_q.push_back(v);
			for (int i = 0; i < WINDOW_LEN; i++) begin
				recent_bytes[i] = 8'h00;
			end
			kw_seen = '0;
		end
	endtask

	task automatic add_item(input logic [7:0] ch, input logic last, input logic bear);
		text_item_t it;
		it.ch = ch;
		it.last = last;
		it.bear = bear;
		text_stream_q.push_back(it);
		if (last) begin
			texts_built++;
		end
	endtask

	// Whole text from a string, final byte flagged
	task automatic add_text(input string s, input logic bear);
		for (int j = 0; j < s.len(); j++) begin
			add_item(s[j], j == s.len() - 1, (j == s.len() - 1) ? bear : 1'($urandom));
		end
	endtask

	// Lower case letter turned upper now and then
	function automatic logic [7:0] mix_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 3) == 0) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	// Random text: keywords, damaged keywords, separators, filler and noise
	task automatic make_text();
		logic [7:0] txt [$];
		logic [7:0] c;
		string      w;
		string      seps;
		int         pieces;
		int         kind;
		int         n;
		seps = " ,.-:!";
		pieces = $urandom_range(1, 4);
		for (int p = 0; p < pieces; p++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				w = kw_text[$urandom_range(0, TABLE_SIZE - 1)];
				for (int j = 0; j < w.len(); j++) begin
					txt.push_back(mix_case(w[j]));
				end
			end else if (kind == 4) begin
				// cut short or one letter altered
				w = kw_text[$urandom_range(0, TABLE_SIZE - 1)];
				n = $urandom_range(1, w.len() - 1);
				if ($urandom_range(0, 1) == 0) begin
					for (int j = 0; j < n; j++) begin
						txt.push_back(mix_case(w[j]));
					end
				end else begin
					for (int j = 0; j < w.len(); j++) begin
						c = w[j];
						txt.push_back((j == n) ? (c ^ 8'h01) : mix_case(c));
					end
				end
			end else if (kind <= 6) begin
				n = $urandom_range(1, 3);
				for (int j = 0; j < n; j++) begin
					txt.push_back(seps[$urandom_range(0, seps.len() - 1)]);
				end
			end else if (kind == 7) begin
				n = $urandom_range(1, 6);
				for (int j = 0; j < n; j++) begin
					txt.push_back(mix_case(8'h61 + 8'($urandom_range(0, 25))));
				end
			end else if (kind == 8) begin
				n = $urandom_range(1, 4);
				for (int j = 0; j < n; j++) begin
					txt.push_back(8'($urandom_range(0, 255)));
				end
			end
		end
		if (txt.size() == 0) begin
			txt.push_back(8'($urandom_range(0, 255)));
		end
		for (int j = 0; j < txt.size(); j++) begin
			add_item(txt[j], j == txt.size() - 1, 1'($urandom));
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		// directed: byte extremes with no match, both fallback verdicts
		add_item(8'h00, 1'b1, 1'b1);
		add_item(8'hFF, 1'b1, 1'b0);
		// upper case folding, a match beats the bearish fallback
		add_text("FLOOD", 1'b1);
		// keyword split over two texts must not match
		add_text("rio", 1'b0);
		add_text("t", 1'b1);
		// zero byte inside a keyword breaks it
		add_item("r", 1'b0, 1'b1);
		add_item("i", 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		add_item("o", 1'b0, 1'b0);
		add_item("t", 1'b1, 1'b0);
		add_text("bank run", 1'b0);

		while (text_stream_q.size() < ITEM_TARGET || texts_built < MIN_TEXTS) begin
			make_text();
		end
		total_items = text_stream_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < total_items) @(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (verdict_q.size() != 0) begin
			mismatches += verdict_q.size();
			$display("ERROR: %0d verdicts never arrived", verdict_q.size());
		end
		$display("Run: %0d bytes in %0d texts, %0d verdicts checked, %0d errors",
			bytes_sent, texts_built, results_seen, mismatches);
		$display("Verdict levels none/low/medium/high/critical: %0d/%0d/%0d/%0d/%0d",
			level_tally[0], level_tally[1], level_tally[2], level_tally[3],
			level_tally[4]);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Driver: offers queued bytes with random gaps, predicts on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				classify_byte({text_byte, end_of_text, bearish});
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_wait != 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (text_stream_q.size() != 0) begin
					{text_byte, end_of_text, bearish} <= text_stream_q.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0) begin
						tx_calm = !tx_calm;
					end
					tx_wait = tx_calm ? 0 : $urandom_range(0, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each verdict against the oldest prediction, stalls at random
	always @(posedge clk) begin
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				level_tally[threat_level]++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: verdict with no text pending: lvl %0d cat %0d conf %0d idx %0d",
							threat_level, category, confidence_pct, pattern_index);
					end
				end else begin
					want = verdict_q.pop_front();
					if (threat_level !== want.level || category !== want.cat ||
							confidence_pct !== want.conf || pattern_index !== want.index) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: verdict %0d expected lvl %0d cat %0d conf %0d idx %0d, got lvl %0d cat %0d conf %0d idx %0d",
								results_seen, want.level, want.cat, want.conf, want.index,
								threat_level, category, confidence_pct, pattern_index);
						end
					end
				end
				if ($urandom_range(0, 15) == 0) begin
					rx_calm = !rx_calm;
				end
				// long hold-offs so the sender backs up into the block
				if (results_seen == 12 || results_seen == 40) begin
					rx_wait = HOLD_CYCLES;
				end else begin
					rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
				end
			end
			if (rx_wait != 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/pkc_pkg.sv
rtl/core/pkc_match.sv
rtl/core/pkc_resolve.sv
rtl/core/priority_keyword_classifier.sv
test/tb_top.sv
